FILE: hw/rtl/b64_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_pkg
// Shared types, constants and the symbol-to-ASCII mapping of the encoder.
// ----------------------------------------------------------------------------
package b64_pkg;

  localparam logic [7:0] PAD_CHAR     = 8'h3D;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_USCORE  = 8'h5F;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_EN   = 2'd1;

  // number of 6-bit data symbols in one queued group
  localparam logic [2:0] NSYM_ONE_BYTE  = 3'd2;
  localparam logic [2:0] NSYM_TWO_BYTES = 3'd3;
  localparam logic [2:0] NSYM_FULL      = 3'd4;

  typedef struct packed {
    logic [23:0] bits;
    logic [2:0]  nsym;
    logic        fin;
  } b64_grp_t;

  function automatic logic [7:0] b64_sym_char(logic [5:0] s, logic url);
    logic [7:0] c;
    begin
      if (s < 6'd26) begin
        c = CHAR_UPPER_A + {2'b00, s};
      end else if (s < 6'd52) begin
        c = CHAR_LOWER_A + {2'b00, s - 6'd26};
      end else if (s < 6'd62) begin
        c = CHAR_DIGIT_0 + {2'b00, s - 6'd52};
      end else if (s == 6'd62) begin
        c = url ? CHAR_MINUS : CHAR_PLUS;
      end else begin
        c = url ? CHAR_USCORE : CHAR_SLASH;
      end
      return c;
    end
  endfunction

endpackage

FILE: hw/rtl/b64_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_in_if
// Byte channel into the encoder: raw byte plus end-of-message flag.
// ----------------------------------------------------------------------------
interface b64_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

FILE: hw/rtl/b64_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_out_if
// Character channel out of the encoder: ASCII code plus last-character flag.
// ----------------------------------------------------------------------------
interface b64_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       final_char;

  modport source (output valid, output char_out, output final_char, input ready);
  modport sink   (input valid, input char_out, input final_char, output ready);
endinterface

FILE: hw/rtl/base64_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_encoder
// Streaming Base64 encoder: bytes in, ASCII characters out, with a selectable
// alphabet and optional '=' padding.
// ----------------------------------------------------------------------------
// path: a byte that closes a group (or the final byte) goes through the queue,
//   the group register and the output register before the first character
// throughput: one byte per cycle until the group queue fills; sustained one
//   character per cycle at the output register while out_ch.ready is high
// reset: synchronous, clears the pending bytes, the queue and the output;
//   the alphabet select resets to standard and padding to enabled
module base64_encoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                             clk,
  input  logic                             rst_n,
  b64_in_if.sink                           in_ch,
  b64_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [b64_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic                             cfg_wdata
);

  logic alpha_url_r, alpha_url_nxt;
  logic pad_en_r, pad_en_nxt;

  logic              q_full;
  logic              q_push;
  b64_pkg::b64_grp_t q_wdata;
  logic              q_pop;
  logic              q_valid;
  b64_pkg::b64_grp_t q_rdata;

  always_comb begin
    alpha_url_nxt = alpha_url_r;
    pad_en_nxt    = pad_en_r;
    if (cfg_we) begin
      case (cfg_index)
        b64_pkg::CFG_ALPHABET: alpha_url_nxt = cfg_wdata;
        b64_pkg::CFG_PAD_EN:   pad_en_nxt    = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_url_r <= 1'b0;
      pad_en_r    <= 1'b1;
    end else begin
      alpha_url_r <= alpha_url_nxt;
      pad_en_r    <= pad_en_nxt;
    end
  end

  b64_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  b64_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  b64_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .alpha_url (alpha_url_r),
    .pad_en    (pad_en_r),
    .q_valid   (q_valid),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_ch    (out_ch)
  );

endmodule

FILE: hw/rtl/b64_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_front
// Collects bytes into groups of three, or fewer at the final byte, for the queue.
// ----------------------------------------------------------------------------
module b64_front (
  input  logic              clk,
  input  logic              rst_n,
  b64_in_if.sink            in_ch,
  input  logic              q_full,
  output logic              q_push,
  output b64_pkg::b64_grp_t q_data
);

  logic [1:0]  cnt_r, cnt_nxt;
  logic [15:0] pend_r, pend_nxt;
  logic        accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    cnt_nxt     = cnt_r;
    pend_nxt    = pend_r;
    q_push      = 1'b0;
    q_data.fin  = in_ch.final_byte;
    q_data.bits = {pend_r, in_ch.data_byte};
    q_data.nsym = b64_pkg::NSYM_FULL;
    case (cnt_r)
      2'd0: begin
        q_data.bits = {in_ch.data_byte, 16'h0000};
        q_data.nsym = b64_pkg::NSYM_ONE_BYTE;
      end
      2'd1: begin
        q_data.bits = {pend_r[15:8], in_ch.data_byte, 8'h00};
        q_data.nsym = b64_pkg::NSYM_TWO_BYTES;
      end
      default: begin
        q_data.bits = {pend_r, in_ch.data_byte};
        q_data.nsym = b64_pkg::NSYM_FULL;
      end
    endcase
    if (accept) begin
      if (in_ch.final_byte || cnt_r[1]) begin
        q_push   = 1'b1;
        cnt_nxt  = 2'd0;
        pend_nxt = 16'h0000;
      end else if (cnt_r == 2'd0) begin
        cnt_nxt  = 2'd1;
        pend_nxt = {in_ch.data_byte, 8'h00};
      end else begin
        cnt_nxt  = 2'd2;
        pend_nxt = {pend_r[15:8], in_ch.data_byte};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 2'd0;
      pend_r <= 16'h0000;
    end else begin
      cnt_r  <= cnt_nxt;
      pend_r <= pend_nxt;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("pending count out of range");

endmodule

FILE: hw/rtl/b64_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_queue
// Small group queue between the byte collector and the character emitter.
// ----------------------------------------------------------------------------
module b64_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  b64_pkg::b64_grp_t wdata,
  output logic              full,
  input  logic              pop,
  output logic              rvalid,
  output b64_pkg::b64_grp_t rdata
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  b64_pkg::b64_grp_t mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  assign full   = (cnt_r == CNT_W'(DEPTH));
  assign rvalid = (cnt_r != '0);
  assign rdata  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full && !pop))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && !rvalid))
    else $error("pop from empty queue");

endmodule

FILE: hw/rtl/b64_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_back
// Takes one group from the queue and emits its characters, one per cycle while
// ready, via an output register, with padding and the last-character flag.
// ----------------------------------------------------------------------------
module b64_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              alpha_url,
  input  logic              pad_en,
  input  logic              q_valid,
  input  b64_pkg::b64_grp_t q_data,
  output logic              q_pop,
  b64_out_if.source         out_ch
);

  logic              grp_valid_r, grp_valid_nxt;
  b64_pkg::b64_grp_t grp_r;
  logic [1:0]        k_r, k_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_char_r;
  logic              out_final_r;

  logic [2:0] total;
  logic       last_char;
  logic       out_load;
  logic       grp_done;
  logic [5:0] sym;
  logic [7:0] char_sel;

  assign total     = (grp_r.fin && pad_en) ? b64_pkg::NSYM_FULL : grp_r.nsym;
  assign last_char = (k_r == 2'(total - 3'd1));
  assign out_load  = grp_valid_r && (!out_valid_r || out_ch.ready);
  assign grp_done  = out_load && last_char;
  assign q_pop     = q_valid && (!grp_valid_r || grp_done);

  always_comb begin
    case (k_r)
      2'd0:    sym = grp_r.bits[23:18];
      2'd1:    sym = grp_r.bits[17:12];
      2'd2:    sym = grp_r.bits[11:6];
      default: sym = grp_r.bits[5:0];
    endcase
    char_sel = ({1'b0, k_r} < grp_r.nsym) ? b64_pkg::b64_sym_char(sym, alpha_url)
                                           : b64_pkg::PAD_CHAR;
  end

  always_comb begin
    grp_valid_nxt = grp_valid_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      k_nxt         = k_r + 1'b1;
    end
    if (grp_done) begin
      grp_valid_nxt = 1'b0;
      k_nxt         = 2'd0;
    end
    if (q_pop) begin
      grp_valid_nxt = 1'b1;
      k_nxt         = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_valid_r <= 1'b0;
      k_r         <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      grp_valid_r <= grp_valid_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      grp_r <= q_data;
    end
    if (out_load) begin
      out_char_r  <= char_sel;
      out_final_r <= last_char && grp_r.fin;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.char_out   = out_char_r;
  assign out_ch.final_char = out_final_r;

  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    grp_valid_r |-> ({1'b0, k_r} < total))
    else $error("character index past end of group");
  a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && grp_valid_r) |-> grp_done)
    else $error("group overwritten before its last character");

endmodule
